/* hdl/ibd_pkg.sv */
package ibd_pkg;

  // Geometry limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_FACTOR = 16;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  // Reciprocal divide: quotient = (sum * mult) >> RECIP_SHIFT
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 23;
  localparam int SUM_W       = 16;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SCALE  = 2'd0,
    REG_COLOR  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } ibd_reg_t;

  // Per-transaction control carried alongside the lanes
  typedef struct packed {
    logic              valid;
    logic              wen;        // pixel lies in a whole block
    logic              first;      // top-left pixel of its block
    logic              emit;       // bottom-right pixel of its block
    logic              row_end;
    logic              frame_end;
    logic              bypass;     // previous transaction wrote the same column
    logic [1:0]        shift;      // Gaussian weight as a left shift
    logic [ADDR_W-1:0] addr;
  } ibd_stage_t;

  // Odd factors act as 3, zero as 2, oversized even factors clamp
  function automatic logic [4:0] eff_factor(input logic [4:0] f);
    logic [4:0] r;
    if (f[0]) begin
      r = 5'd3;
    end else if (f < 5'd2) begin
      r = 5'd2;
    end else if (f > 5'(MAX_FACTOR)) begin
      r = 5'(MAX_FACTOR) & 5'b11110;
    end else begin
      r = f;
    end
    return r;
  endfunction

  // ceil(2^24 / divisor); divisor is f*f for even f, 16 for the Gaussian
  function automatic logic [RECIP_W-1:0] recip_mult(input logic [4:0] f);
    logic [RECIP_W-1:0] m;
    unique case (f)
      5'd2:    m = 23'd4194304;
      5'd4:    m = 23'd1048576;
      5'd6:    m = 23'd466034;
      5'd8:    m = 23'd262144;
      5'd10:   m = 23'd167773;
      5'd12:   m = 23'd116509;
      5'd14:   m = 23'd85599;
      5'd16:   m = 23'd65536;
      default: m = 23'd1048576;
    endcase
    return m;
  endfunction

endpackage

/* hdl/ibd_lane.sv */
module ibd_lane (
  input  logic                                clk,
  input  logic                                in_fire,
  input  logic [7:0]                          in_sample,
  input  logic [ibd_pkg::ADDR_W-1:0]          rd_addr,
  input  ibd_pkg::ibd_stage_t                 p1,
  input  logic [ibd_pkg::RECIP_W-1:0]         recip,
  output logic [7:0]                          quot
);

  // Column accumulator memory for this channel
  logic [ibd_pkg::SUM_W-1:0] col_mem_r [ibd_pkg::LINE_DEPTH];
  logic [ibd_pkg::SUM_W-1:0] rdata_r;
  logic [ibd_pkg::SUM_W-1:0] sum_r;
  logic [ibd_pkg::SUM_W-1:0] sum_nxt;
  logic [ibd_pkg::SUM_W-1:0] base;
  logic [7:0]                smp_r;
  logic [ibd_pkg::SUM_W+ibd_pkg::RECIP_W-1:0] prod;

  // Accumulate: restart on the first pixel, forward the last write if it
  // landed in the same cycle as our read
  always_comb begin
    if (p1.first) begin
      base = '0;
    end else if (p1.bypass) begin
      base = sum_r;
    end else begin
      base = rdata_r;
    end
    sum_nxt = base + (ibd_pkg::SUM_W'(smp_r) << p1.shift);
  end

  always_ff @(posedge clk) begin
    rdata_r <= col_mem_r[rd_addr];
    if (p1.valid && p1.wen) begin
      col_mem_r[p1.addr] <= sum_nxt;
    end
    if (in_fire) begin
      smp_r <= in_sample;
    end
    if (p1.valid) begin
      sum_r <= sum_nxt;
    end
  end

  // Divide by multiplying with the reciprocal
  assign prod = (ibd_pkg::SUM_W + ibd_pkg::RECIP_W)'(sum_r)
              * (ibd_pkg::SUM_W + ibd_pkg::RECIP_W)'(recip);
  assign quot = prod[ibd_pkg::RECIP_SHIFT +: 8];

endmodule

/* hdl/ibd_ctrl.sv */
module ibd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [12:0]                 cfg_data,
  input  logic                        in_fire,
  output logic [ibd_pkg::ADDR_W-1:0]  rd_addr,
  output logic [ibd_pkg::RECIP_W-1:0] recip,
  output logic                        color,
  output ibd_pkg::ibd_stage_t         p1,
  output ibd_pkg::ibd_stage_t         p2
);

  // Configuration registers
  logic [4:0]  scale_r;
  logic        color_r;
  logic [12:0] width_r;
  logic [12:0] height_r;

  // Position counters
  logic [11:0] icol_r, icol_nxt;
  logic [11:0] irow_r, irow_nxt;
  logic [3:0]  cib_r, cib_nxt;
  logic [3:0]  rib_r, rib_nxt;
  logic [ibd_pkg::ADDR_W-1:0] ocol_r, ocol_nxt;
  logic        col_ok_r, row_ok_r;

  ibd_pkg::ibd_stage_t p1_r, p2_r, p1_nxt;

  logic [4:0]  f;
  logic [12:0] w_eff, h_eff;
  logic        cok, rok, gauss;

  always_comb begin
    f     = ibd_pkg::eff_factor(scale_r);
    gauss = f[0];
    if (width_r == 13'd0) begin
      w_eff = 13'd1;
    end else if (width_r > 13'(ibd_pkg::MAX_WIDTH)) begin
      w_eff = 13'(ibd_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r == 13'd0) begin
      h_eff = 13'd1;
    end else if (height_r > 13'(ibd_pkg::MAX_HEIGHT)) begin
      h_eff = 13'(ibd_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
  end

  // Block fits test, taken at the first column / row of each block
  always_comb begin
    cok = (cib_r == 4'd0) ? (14'(icol_r) + 14'(f) <= 14'(w_eff)) : col_ok_r;
    rok = (rib_r == 4'd0) ? (14'(irow_r) + 14'(f) <= 14'(h_eff)) : row_ok_r;
  end

  // Stage control for the incoming pixel
  always_comb begin
    p1_nxt           = '0;
    p1_nxt.valid     = in_fire;
    p1_nxt.wen       = cok && rok;
    p1_nxt.first     = (cib_r == 4'd0) && (rib_r == 4'd0);
    p1_nxt.emit      = cok && rok && ({1'b0, cib_r} == f - 5'd1)
                       && ({1'b0, rib_r} == f - 5'd1);
    p1_nxt.row_end   = 14'(icol_r) + 14'd1 + 14'(f) > 14'(w_eff);
    p1_nxt.frame_end = p1_nxt.row_end
                       && (14'(irow_r) + 14'd1 + 14'(f) > 14'(h_eff));
    p1_nxt.bypass    = p1_r.valid && p1_r.wen && (p1_r.addr == ocol_r);
    p1_nxt.shift     = gauss ? (2'(cib_r == 4'd1) + 2'(rib_r == 4'd1)) : 2'd0;
    p1_nxt.addr      = ocol_r;
  end

  // Raster position advance
  always_comb begin
    icol_nxt = icol_r;
    irow_nxt = irow_r;
    cib_nxt  = cib_r;
    rib_nxt  = rib_r;
    ocol_nxt = ocol_r;
    if (13'(icol_r) + 13'd1 >= w_eff) begin
      icol_nxt = '0;
      cib_nxt  = '0;
      ocol_nxt = '0;
      if (13'(irow_r) + 13'd1 >= h_eff) begin
        irow_nxt = '0;
        rib_nxt  = '0;
      end else begin
        irow_nxt = irow_r + 12'd1;
        rib_nxt  = ({1'b0, rib_r} + 5'd1 >= f) ? 4'd0 : rib_r + 4'd1;
      end
    end else begin
      icol_nxt = icol_r + 12'd1;
      if ({1'b0, cib_r} + 5'd1 >= f) begin
        cib_nxt  = '0;
        ocol_nxt = ocol_r + ibd_pkg::ADDR_W'(1);
      end else begin
        cib_nxt = cib_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 5'd2;
      color_r  <= 1'b1;
      width_r  <= 13'(ibd_pkg::MAX_WIDTH);
      height_r <= 13'(ibd_pkg::MAX_HEIGHT);
      icol_r   <= '0;
      irow_r   <= '0;
      cib_r    <= '0;
      rib_r    <= '0;
      ocol_r   <= '0;
      col_ok_r <= 1'b0;
      row_ok_r <= 1'b0;
      p1_r     <= '0;
      p2_r     <= '0;
    end else begin
      p1_r <= p1_nxt;
      p2_r <= p1_r;
      if (cfg_we) begin
        // any write restarts the frame
        unique case (ibd_pkg::ibd_reg_t'(cfg_addr))
          ibd_pkg::REG_SCALE:  scale_r  <= cfg_data[4:0];
          ibd_pkg::REG_COLOR:  color_r  <= cfg_data[0];
          ibd_pkg::REG_WIDTH:  width_r  <= cfg_data;
          ibd_pkg::REG_HEIGHT: height_r <= cfg_data;
        endcase
        icol_r <= '0;
        irow_r <= '0;
        cib_r  <= '0;
        rib_r  <= '0;
        ocol_r <= '0;
      end else if (in_fire) begin
        icol_r   <= icol_nxt;
        irow_r   <= irow_nxt;
        cib_r    <= cib_nxt;
        rib_r    <= rib_nxt;
        ocol_r   <= ocol_nxt;
        col_ok_r <= cok;
        row_ok_r <= rok;
      end
    end
  end

  assign rd_addr = ocol_r;
  assign recip   = ibd_pkg::recip_mult(f);
  assign color   = color_r;
  assign p1      = p1_r;
  assign p2      = p2_r;

endmodule

/* hdl/image_block_downscaler.sv */
// Downscales a raster pixel stream by an integer factor: an even factor
// gives the truncated mean of each factor-by-factor block, any odd factor
// gives the 3x3 Gaussian (1 2 1 / 2 4 2 / 1 2 1) sum divided by 16. Pixels
// outside the last whole block column or row are consumed and dropped.
// Three channel lanes each keep a 2048-entry column-sum memory; in grey
// mode only the first channel is meaningful and the others read zero.
// Rate: pixels that do not complete a block are taken one per clock. The
// pixel that completes a block holds off input while its sum passes the
// memory read-modify-write and the reciprocal multiplier into the output
// register, and input also waits while a finished result sits unaccepted.
// A block result passes the p1 and p2 stage registers into the output
// register. Any configuration write restarts the frame.
module image_block_downscaler (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_data,
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // chan_a[7:0], chan_b[15:8], chan_c[23:16]
  // downscaled output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // res_a[7:0], res_b[15:8], res_c[23:16]
  output logic        out_tlast,  // row_end
  output logic [0:0]  out_tuser   // frame_end
);

  logic                        in_fire;
  logic [ibd_pkg::ADDR_W-1:0]  rd_addr;
  logic [ibd_pkg::RECIP_W-1:0] recip;
  logic                        color;
  ibd_pkg::ibd_stage_t         p1, p2;
  logic [7:0]                  q_a, q_b, q_c;

  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;
  logic        out_tlast_r;
  logic        out_tuser_r;
  logic        load_out;

  ibd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_fire  (in_fire),
    .rd_addr  (rd_addr),
    .recip    (recip),
    .color    (color),
    .p1       (p1),
    .p2       (p2)
  );

  ibd_lane u_lane_a (
    .clk       (clk),
    .in_fire   (in_fire),
    .in_sample (in_tdata[7:0]),
    .rd_addr   (rd_addr),
    .p1        (p1),
    .recip     (recip),
    .quot      (q_a)
  );

  ibd_lane u_lane_b (
    .clk       (clk),
    .in_fire   (in_fire),
    .in_sample (in_tdata[15:8]),
    .rd_addr   (rd_addr),
    .p1        (p1),
    .recip     (recip),
    .quot      (q_b)
  );

  ibd_lane u_lane_c (
    .clk       (clk),
    .in_fire   (in_fire),
    .in_sample (in_tdata[23:16]),
    .rd_addr   (rd_addr),
    .p1        (p1),
    .recip     (recip),
    .quot      (q_c)
  );

  // Hold input while a block result is in flight or the output is stuck
  assign in_tready = !(p1.valid && p1.emit) && !(p2.valid && p2.emit)
                     && (!out_tvalid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign load_out  = p2.valid && p2.emit;

  // Merge lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata_r <= {color ? q_c : 8'd0, color ? q_b : 8'd0, q_a};
      out_tlast_r <= p2.row_end;
      out_tuser_r <= p2.frame_end;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tuser  = out_tuser_r;

  // A result reaching the output register always finds it free
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_tvalid_r || out_tready))
    else $error("block result overwrote a pending transaction");

  // Never more than one block result in flight
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !((p1.valid && p1.emit) && (p2.valid && p2.emit)))
    else $error("two block results in flight");

  // Frame end only on the last pixel of a row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_tuser_r) |-> out_tlast_r)
    else $error("frame end without row end");

  // A block-completing pixel in stage p1 goes on through p2 and sets the output valid
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (p1.valid && p1.emit) |=> ##1 out_tvalid_r)
    else $error("block result did not reach the output");

endmodule
